@@ sv/usmg_pkg.sv @@
// ============================================================================
// usmg_pkg
// Shared types, widths and constants of the UV sphere mesh generator.
// ============================================================================
package usmg_pkg;

    // Field and datapath widths
    localparam int CNT_W   = 9;    // sector / stack counts and indexes
    localparam int IDX_W   = 17;   // vertex index
    localparam int RAD_W   = 16;   // radius, unsigned Q8.8
    localparam int POS_W   = 16;   // positions, signed Q8.8
    localparam int TEX_W   = 16;   // texture coordinates, Q1.15
    localparam int ANG_W   = 32;   // angle as a fraction of a full turn
    localparam int CV_W    = 33;   // CORDIC datapath, Q2.30 plus guard bit
    localparam int DIV_W   = 41;   // divider dividend / quotient
    localparam int PROD_W  = 2 * CV_W;

    // CORDIC
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam logic signed [CV_W-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [ANG_W-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [TEX_W-1:0] ONE_Q15      = 16'h8000;

    // Parameter defaults
    localparam int DEF_MAX_SECTORS = 256;
    localparam int DEF_MAX_STACKS  = 256;

    // Configuration register indexes and reset values
    localparam int REG_ADDR_W = 2;
    localparam logic [REG_ADDR_W-1:0] REG_RADIUS  = 2'd0;
    localparam logic [REG_ADDR_W-1:0] REG_SECTORS = 2'd1;
    localparam logic [REG_ADDR_W-1:0] REG_STACKS  = 2'd2;
    localparam logic [RAD_W-1:0] RADIUS_RST  = 16'd256;
    localparam logic [CNT_W-1:0] SECTORS_RST = 9'd36;
    localparam logic [CNT_W-1:0] STACKS_RST  = 9'd18;

    // Item kinds
    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    // One result item
    typedef struct packed {
        logic                    last;
        logic [IDX_W-1:0]        corner_c;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_a;
        logic [TEX_W-1:0]        tex_v;
        logic [TEX_W-1:0]        tex_u;
        logic signed [POS_W-1:0] pos_z;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_x;
        logic                    kind;
    } t_item;

    // atan(2^-k) as a fraction of a full turn, 2^32 per turn
    function automatic logic [ANG_W-1:0] atan_turn(input logic [STEP_W-1:0] k);
        logic [ANG_W-1:0] a;
        unique case (k)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ sv/usmg_div.sv @@
// ============================================================================
// usmg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module usmg_div
    import usmg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    localparam int CW = $clog2(DIV_W);
    localparam logic [CW-1:0] LAST_BIT = CW'(DIV_W - 1);

    logic             r_busy, r_done;
    logic [CW-1:0]    r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [CNT_W-1:0] r_rem, r_den;

    logic [CNT_W:0]   trial;
    logic             ge;

    // trial subtract of the next dividend bit
    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]};
        ge    = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_BIT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift in as dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? CNT_W'(trial - {1'b0, r_den}) : trial[CNT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ sv/usmg_cordic.sv @@
// ============================================================================
// usmg_cordic
// Rotation CORDIC, one micro-rotation per cycle, cosine and sine in Q2.30.
// ============================================================================
module usmg_cordic
    import usmg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [ANG_W-1:0]       i_angle,
    output logic                   o_done,
    output logic signed [CV_W-1:0] o_cos,
    output logic signed [CV_W-1:0] o_sin
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    logic                   r_busy, r_done, r_flip;
    logic [STEP_W-1:0]      r_step;
    logic signed [CV_W-1:0] r_x, r_y, r_z;

    logic                   flip;
    logic [ANG_W-1:0]       turn;
    logic signed [CV_W-1:0] dx, dy, da;

    // fold the angle into [-90deg, 90deg)
    always_comb begin
        flip = (i_angle[ANG_W-1:ANG_W-2] == 2'b01) || (i_angle[ANG_W-1:ANG_W-2] == 2'b10);
        turn = flip ? i_angle + HALF_TURN : i_angle;
    end

    // one micro-rotation
    always_comb begin
        dx = r_y >>> r_step;
        dy = r_x >>> r_step;
        da = $signed({1'b0, atan_turn(r_step)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= $signed({turn[ANG_W-1], turn});
            r_flip <= flip;
        end else if (r_busy) begin
            if (!r_z[CV_W-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - da;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + da;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule

@@ sv/uv_sphere_mesh_generator.sv @@
// ============================================================================
// uv_sphere_mesh_generator
// Walks a UV sphere: vertices in stack-major order, then triangles, one
// mesh item per input transfer.
// ============================================================================
//
//  Channel   Dir  Signals                      Content
//  s_axis    in   tvalid/tready/tdata[7:0]     restart in bit 0
//  m_axis    out  tvalid/tready/tdata/tuser/   positions, texture, corners;
//                 tlast                        tuser = kind, tlast = end of mesh
//  cfg       in   valid/ready/addr/data        radius, sector count, stack count;
//                                              ready only between items
//
//  A vertex runs a settle step, four divisions and two CORDIC runs on the shared
//  divider and rotator, the multiply steps, a post-settle step and a load step.
//  A triangle runs a settle step, a corner step, a post-settle step and a load
//  step. Settling also steps past any skipped positions. One item is in work at
//  a time; a finished item waits in the output register while the next one is
//  accepted and computed, and the load step holds while that register is still
//  occupied.
//  Reset is synchronous and returns the walk to the first vertex.
//
module uv_sphere_mesh_generator
    import usmg_pkg::*;
#(
    parameter int MAX_SECTORS = DEF_MAX_SECTORS,
    parameter int MAX_STACKS  = DEF_MAX_STACKS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [0] restart
    // output stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [63:48] tex_u,
    // [79:64] tex_v, [96:80] corner_a, [113:97] corner_b, [130:114] corner_c
    output logic [135:0]          o_m_axis_tdata,
    output logic                  o_m_axis_tuser,   // [0] item_kind
    output logic                  o_m_axis_tlast,   // end_of_mesh
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [REG_ADDR_W-1:0] i_cfg_addr,
    input  logic [RAD_W-1:0]      i_cfg_data
);

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_PRE     = 4'd1;
    localparam logic [3:0] S_DIV_LON = 4'd2;
    localparam logic [3:0] S_DIV_LAT = 4'd3;
    localparam logic [3:0] S_DIV_U   = 4'd4;
    localparam logic [3:0] S_DIV_V   = 4'd5;
    localparam logic [3:0] S_COR_LAT = 4'd6;
    localparam logic [3:0] S_COR_LON = 4'd7;
    localparam logic [3:0] S_MUL     = 4'd8;
    localparam logic [3:0] S_TRI     = 4'd9;
    localparam logic [3:0] S_POST    = 4'd10;
    localparam logic [3:0] S_FIN     = 4'd11;

    localparam logic [2:0] MUL_LAST = 3'd4;

    // ------------------------------------------------------------------
    // Round half up by k bits and saturate to 16 bits
    function automatic logic [POS_W-1:0] round_sat(input logic signed [PROD_W-1:0] p,
                                                   input int k);
        logic signed [PROD_W:0] t;
        t = (($signed((PROD_W+1)'(p))) + ($signed((PROD_W+1)'(1)) <<< (k - 1))) >>> k;
        if (t > $signed((PROD_W+1)'(32767)))
            return 16'h7FFF;
        else if (t < -$signed((PROD_W+1)'(32768)))
            return 16'h8000;
        else
            return t[POS_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    logic [RAD_W-1:0] r_radius;
    logic [CNT_W-1:0] r_sectors, r_stacks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= RADIUS_RST;
            r_sectors <= SECTORS_RST;
            r_stacks  <= STACKS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                REG_RADIUS:  r_radius  <= i_cfg_data;
                REG_SECTORS: r_sectors <= i_cfg_data[CNT_W-1:0];
                REG_STACKS:  r_stacks  <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // writes only between items
    assign o_cfg_ready = (r_state == S_IDLE);

    // effective counts: zero acts as one, clamp at the maximum
    logic [CNT_W-1:0] ns, nt;

    always_comb begin
        if (r_sectors == '0)
            ns = CNT_W'(1);
        else if (32'(r_sectors) > 32'(MAX_SECTORS))
            ns = CNT_W'(MAX_SECTORS);
        else
            ns = r_sectors;
        if (r_stacks == '0)
            nt = CNT_W'(1);
        else if (32'(r_stacks) > 32'(MAX_STACKS))
            nt = CNT_W'(MAX_STACKS);
        else
            nt = r_stacks;
    end

    // ------------------------------------------------------------------
    // State
    logic [3:0]              r_state, n_state;
    logic                    r_sub, n_sub;
    logic                    r_phase, n_phase;
    logic [CNT_W-1:0]        r_stk, n_stk, r_sec, n_sec;
    logic                    r_sec2, n_sec2;
    logic [IDX_W-1:0]        r_rb, n_rb;
    logic                    r_wrap, n_wrap;
    logic [2:0]              r_mstep, n_mstep;
    logic                    r_out_valid, n_out_valid;

    // datapath registers
    logic [ANG_W-1:0]        r_lon, r_lat;
    logic [TEX_W-1:0]        r_u, r_v;
    logic signed [CV_W-1:0]  r_cl, r_sl, r_co, r_so, r_xy;
    logic signed [PROD_W-1:0] r_prod;
    logic [POS_W-1:0]        r_px, r_py, r_pz;
    logic                    r_kind;
    logic [IDX_W-1:0]        r_ca, r_cb, r_cc;
    t_item                   r_out;

    // ------------------------------------------------------------------
    // One step of moving past positions that name no item
    logic             st_done, st_wrap, st_phase, st_sec2;
    logic [CNT_W-1:0] st_stk, st_sec;
    logic [IDX_W-1:0] st_rb, rb_next;

    always_comb begin
        rb_next  = r_rb + IDX_W'(ns) + IDX_W'(1);
        st_done  = 1'b0;
        st_wrap  = 1'b0;
        st_phase = r_phase;
        st_stk   = r_stk;
        st_sec   = r_sec;
        st_sec2  = r_sec2;
        st_rb    = r_rb;
        if (!r_phase) begin
            if (r_sec > ns) begin
                st_sec = '0;
                st_stk = r_stk + 1'b1;
                st_rb  = rb_next;
            end else if (r_stk > nt) begin
                st_phase = 1'b1;
                st_stk   = '0;
                st_sec   = '0;
                st_sec2  = 1'b0;
                st_rb    = '0;
            end else begin
                st_done = 1'b1;
            end
        end else begin
            if (r_sec >= ns) begin
                st_sec  = '0;
                st_sec2 = 1'b0;
                st_stk  = r_stk + 1'b1;
                st_rb   = rb_next;
            end else if (r_stk >= nt) begin
                // past the last row: wrap to the first vertex
                st_phase = 1'b0;
                st_stk   = '0;
                st_sec   = '0;
                st_sec2  = 1'b0;
                st_rb    = '0;
                st_done  = 1'b1;
                st_wrap  = 1'b1;
            end else if ((r_stk == '0 && !r_sec2) ||
                         (r_stk == nt - 1'b1 && r_sec2)) begin
                // top row skips its first triangle, bottom row its second
                st_sec2 = ~r_sec2;
                if (r_sec2)
                    st_sec = r_sec + 1'b1;
            end else begin
                st_done = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared divider and rotator
    logic             div_start, div_done;
    logic [DIV_W-1:0] div_dividend, div_quo;
    logic [CNT_W-1:0] div_divisor;
    logic             cor_start, cor_done;
    logic [ANG_W-1:0] cor_angle;
    logic signed [CV_W-1:0] cor_cos, cor_sin;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = ns;
        unique case (r_state)
            S_DIV_LON: div_dividend = {r_sec, 32'b0};
            S_DIV_LAT: begin
                div_dividend = DIV_W'({r_stk, 31'b0});
                div_divisor  = nt;
            end
            S_DIV_U:   div_dividend = DIV_W'({r_sec, 15'b0}) + DIV_W'(ns >> 1);
            S_DIV_V: begin
                div_dividend = DIV_W'({r_stk, 15'b0}) + DIV_W'(nt >> 1);
                div_divisor  = nt;
            end
            default: ;
        endcase
        if (r_state == S_DIV_LON || r_state == S_DIV_LAT ||
            r_state == S_DIV_U || r_state == S_DIV_V)
            div_start = !r_sub;
        cor_start = (r_state == S_COR_LAT || r_state == S_COR_LON) && !r_sub;
        cor_angle = (r_state == S_COR_LAT) ? r_lat : r_lon;
    end

    usmg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    usmg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_angle),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    // shared multiplier operands
    logic signed [CV_W-1:0] mul_a, mul_b, rad_s;

    always_comb begin
        rad_s = $signed(CV_W'(r_radius));
        mul_a = '0;
        mul_b = '0;
        case (r_mstep)
            3'd0: begin mul_a = rad_s; mul_b = r_cl; end
            3'd1: begin mul_a = rad_s; mul_b = r_sl; end
            3'd2: begin mul_a = r_xy;  mul_b = r_co; end
            3'd3: begin mul_a = r_xy;  mul_b = r_so; end
            default: ;
        endcase
    end

    // triangle corners
    logic [IDX_W-1:0] k1, k2;

    always_comb begin
        k1 = r_rb + IDX_W'(r_sec);
        k2 = k1 + IDX_W'(ns) + IDX_W'(1);
    end

    logic s_xfer, m_xfer;
    assign s_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign m_xfer = o_m_axis_tvalid && i_m_axis_tready;

    // ------------------------------------------------------------------
    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_sub       = r_sub;
        n_phase     = r_phase;
        n_stk       = r_stk;
        n_sec       = r_sec;
        n_sec2      = r_sec2;
        n_rb        = r_rb;
        n_wrap      = r_wrap;
        n_mstep     = r_mstep;
        n_out_valid = m_xfer ? 1'b0 : r_out_valid;
        unique case (r_state)
            S_IDLE: begin
                if (s_xfer) begin
                    n_wrap  = 1'b0;
                    n_state = S_PRE;
                    if (i_s_axis_tdata[0]) begin
                        n_phase = 1'b0;
                        n_stk   = '0;
                        n_sec   = '0;
                        n_sec2  = 1'b0;
                        n_rb    = '0;
                    end
                end
            end
            S_PRE, S_POST: begin
                n_phase = st_phase;
                n_stk   = st_stk;
                n_sec   = st_sec;
                n_sec2  = st_sec2;
                n_rb    = st_rb;
                if (st_done) begin
                    if (r_state == S_POST) begin
                        n_wrap  = st_wrap;
                        n_state = S_FIN;
                    end else begin
                        n_state = st_phase ? S_TRI : S_DIV_LON;
                    end
                end
            end
            S_DIV_LON, S_DIV_LAT, S_DIV_U, S_DIV_V: begin
                n_sub = 1'b1;
                if (r_sub && div_done) begin
                    n_sub = 1'b0;
                    unique case (r_state)
                        S_DIV_LON: n_state = S_DIV_LAT;
                        S_DIV_LAT: n_state = S_DIV_U;
                        S_DIV_U:   n_state = S_DIV_V;
                        default:   n_state = S_COR_LAT;
                    endcase
                end
            end
            S_COR_LAT, S_COR_LON: begin
                n_sub = 1'b1;
                if (r_sub && cor_done) begin
                    n_sub   = 1'b0;
                    n_state = (r_state == S_COR_LAT) ? S_COR_LON : S_MUL;
                end
            end
            S_MUL: begin
                n_mstep = r_mstep + 1'b1;
                if (r_mstep == MUL_LAST) begin
                    n_mstep = '0;
                    n_sec   = r_sec + 1'b1;
                    n_state = S_POST;
                end
            end
            S_TRI: begin
                n_sec2 = ~r_sec2;
                if (r_sec2)
                    n_sec = r_sec + 1'b1;
                n_state = S_POST;
            end
            S_FIN: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sub       <= 1'b0;
            r_phase     <= 1'b0;
            r_stk       <= '0;
            r_sec       <= '0;
            r_sec2      <= 1'b0;
            r_rb        <= '0;
            r_wrap      <= 1'b0;
            r_mstep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sub       <= n_sub;
            r_phase     <= n_phase;
            r_stk       <= n_stk;
            r_sec       <= n_sec;
            r_sec2      <= n_sec2;
            r_rb        <= n_rb;
            r_wrap      <= n_wrap;
            r_mstep     <= n_mstep;
            r_out_valid <= n_out_valid;
        end
    end

    // ------------------------------------------------------------------
    // Datapath captures
    always_ff @(posedge i_clk) begin
        if (r_state == S_PRE && st_done)
            r_kind <= st_phase ? KIND_TRIANGLE : KIND_VERTEX;
        if (r_sub && div_done) begin
            case (r_state)
                S_DIV_LON: r_lon <= div_quo[ANG_W-1:0];
                S_DIV_LAT: r_lat <= QUARTER_TURN - div_quo[ANG_W-1:0];
                S_DIV_U:   r_u   <= div_quo[TEX_W-1:0];
                S_DIV_V:   r_v   <= ONE_Q15 - div_quo[TEX_W-1:0];
                default: ;
            endcase
        end
        if (r_sub && cor_done) begin
            if (r_state == S_COR_LAT) begin
                r_cl <= cor_cos;
                r_sl <= cor_sin;
            end else begin
                r_co <= cor_cos;
                r_so <= cor_sin;
            end
        end
        if (r_state == S_MUL) begin
            r_prod <= mul_a * mul_b;
            case (r_mstep)
                3'd1: r_xy <= CV_W'(r_prod >>> 15);
                3'd2: r_py <= round_sat(r_prod, 30);
                3'd3: r_px <= round_sat(r_prod, 45);
                3'd4: r_pz <= round_sat(r_prod, 45);
                default: ;
            endcase
        end
        if (r_state == S_TRI) begin
            if (!r_sec2) begin
                r_ca <= k1;
                r_cb <= k2;
                r_cc <= k1 + 1'b1;
            end else begin
                r_ca <= k1 + 1'b1;
                r_cb <= k2;
                r_cc <= k2 + 1'b1;
            end
        end
        // output register load
        if (r_state == S_FIN && (!r_out_valid || i_m_axis_tready)) begin
            r_out.kind <= r_kind;
            r_out.last <= r_wrap;
            if (r_kind == KIND_VERTEX) begin
                r_out.pos_x    <= r_px;
                r_out.pos_y    <= r_py;
                r_out.pos_z    <= r_pz;
                r_out.tex_u    <= r_u;
                r_out.tex_v    <= r_v;
                r_out.corner_a <= '0;
                r_out.corner_b <= '0;
                r_out.corner_c <= '0;
            end else begin
                r_out.pos_x    <= '0;
                r_out.pos_y    <= '0;
                r_out.pos_z    <= '0;
                r_out.tex_u    <= '0;
                r_out.tex_v    <= '0;
                r_out.corner_a <= r_ca;
                r_out.corner_b <= r_cb;
                r_out.corner_c <= r_cc;
            end
        end
    end

    // ------------------------------------------------------------------
    // Ports
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tdata  = {5'b0, r_out.corner_c, r_out.corner_b, r_out.corner_a,
                              r_out.tex_v, r_out.tex_u, r_out.pos_z, r_out.pos_y,
                              r_out.pos_x};

endmodule

@@ sv/usmg_checker.sv @@
// ============================================================================
// usmg_checker
// Port-level checks of the UV sphere mesh generator, bound to the top level.
// ============================================================================
module usmg_checker
    import usmg_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [135:0] o_m_axis_tdata,
    input logic         o_m_axis_tuser
);

    // one item in work at a time: ready drops after an input transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted while an item is in work");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // vertex records carry no corners and u stays within one
    a_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_VERTEX |->
            o_m_axis_tdata[130:80] == '0 && o_m_axis_tdata[63:48] <= ONE_Q15)
        else $error("bad vertex record");

    // triangle records carry no position or texture
    a_triangle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_TRIANGLE |-> o_m_axis_tdata[79:0] == '0)
        else $error("bad triangle record");

endmodule

bind uv_sphere_mesh_generator usmg_checker u_usmg_checker (.*);
